### sv/tpld_pkg.sv
package tpld_pkg;

    localparam int LEG_COUNT = 6;
    localparam int LEG_W     = 3;
    localparam int DIV_STEPS = 8;
    localparam int STEP_W    = 3;
    localparam int TERM_W    = 33;
    localparam int ERR_W     = 34;
    localparam int MAG_W     = 33;
    localparam int REM_W     = MAG_W + 8;

    localparam logic [LEG_W-1:0] FIRST_LEG = 3'd2;
    localparam logic [LEG_W-1:0] LAST_IDX  = 3'd5;

    localparam logic [1:0] SET_A = 2'd0;
    localparam logic [1:0] SET_B = 2'd1;

    localparam logic [1:0] REG_ROLL_GAIN      = 2'd0;
    localparam logic [1:0] REG_PITCH_GAIN     = 2'd1;
    localparam logic [1:0] REG_ANGLE_DEADBAND = 2'd2;
    localparam logic [1:0] REG_MIN_NORMALIZER = 2'd3;

    localparam logic [15:0] ROLL_GAIN_RST      = 16'd625;
    localparam logic [15:0] PITCH_GAIN_RST     = 16'd849;
    localparam logic [14:0] ANGLE_DEADBAND_RST = 15'd256;
    localparam logic [15:0] MIN_NORMALIZER_RST = 16'd2560;

    typedef struct packed {
        logic [1:0]         leg_set;
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
    } in_word_t;

    typedef struct packed {
        logic [2:0] leg_number;
        logic       bridge_in_first;
        logic       bridge_in_second;
        logic [7:0] duty;
        logic       last_leg;
    } out_word_t;

    typedef struct packed {
        logic             capture;
        logic             mul_roll;
        logic             mul_pitch;
        logic             norm_step;
        logic             div_load;
        logic             div_step;
        logic             out_load;
        logic [LEG_W-1:0] leg;
    } cmd_t;

    typedef struct packed {
        logic out_stall;
    } status_t;

    function automatic logic signed [ERR_W-1:0] leg_error(
        input logic [1:0]               set,
        input logic [LEG_W-1:0]         leg,
        input logic signed [TERM_W-1:0] rt,
        input logic signed [TERM_W-1:0] pt
    );
        logic signed [ERR_W-1:0] r;
        logic signed [ERR_W-1:0] p;
        logic signed [ERR_W-1:0] e;
        r = {rt[TERM_W-1], rt};
        p = {pt[TERM_W-1], pt};
        e = '0;
        case (set)
            SET_A:
            begin
                case (leg)
                    3'd0:    e = p - r;
                    3'd2:    e = -p - r;
                    3'd4:    e = r <<< 1;
                    default: e = '0;
                endcase
            end
            SET_B:
            begin
                case (leg)
                    3'd1:    e = -(r <<< 1);
                    3'd3:    e = p + r;
                    3'd5:    e = r - p;
                    default: e = '0;
                endcase
            end
            default: e = '0;
        endcase
        return e;
    endfunction

    function automatic logic [MAG_W-1:0] err_mag(input logic signed [ERR_W-1:0] e);
        logic signed [ERR_W-1:0] a;
        a = e[ERR_W-1] ? -e : e;
        return a[MAG_W-1:0];
    endfunction

endpackage

### sv/tilt_proportional_leg_drive.sv
// Takes one tilt sample at a time and returns six words, legs 2 through 7 in
// order, the last flagged by last_leg. For each sample the block accepts it,
// runs the roll and pitch terms in turn through the single shared 17x17
// multiplier, finds the normalizer over all legs, then for each leg forms the
// duty on the shared eight-step restoring divider and emits the word, waiting
// while the output stalls. in_ready is high only between samples; a finished
// word waits in the output register while the next leg is divided. Write
// configuration only while the block is idle.
module tilt_proportional_leg_drive (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  tpld_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tpld_pkg::out_word_t out_data
);
    import tpld_pkg::*;

    cmd_t    cmd;
    status_t status;

    tpld_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tpld_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_data      (in_data),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("block ready right after taking a sample");

    a_last_is_leg7: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.last_leg) |-> (out_data.leg_number == 3'd7))
        else $error("last word not on leg 7");

    a_bridge_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.bridge_in_first && out_data.bridge_in_second))
        else $error("both bridge inputs high");

    a_drive_has_duty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.bridge_in_first || out_data.bridge_in_second))
        |-> (out_data.duty != 8'd0))
        else $error("leg driven with zero duty");

endmodule

### sv/tpld_ctrl.sv
module tpld_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  tpld_pkg::status_t status,
    output tpld_pkg::cmd_t    cmd
);
    import tpld_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_ROLL,
        S_MUL_PITCH,
        S_NORM,
        S_DIV_LOAD,
        S_DIV,
        S_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [LEG_W-1:0]  leg_reg, leg_next;
    logic [STEP_W-1:0] step_reg, step_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        leg_next   = leg_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.leg    = leg_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_MUL_ROLL;
                end
            end
            S_MUL_ROLL:
            begin
                cmd.mul_roll = 1'b1;
                state_next   = S_MUL_PITCH;
            end
            S_MUL_PITCH:
            begin
                cmd.mul_pitch = 1'b1;
                leg_next      = '0;
                state_next    = S_NORM;
            end
            S_NORM:
            begin
                cmd.norm_step = 1'b1;
                if (leg_reg == LAST_IDX)
                begin
                    leg_next   = '0;
                    state_next = S_DIV_LOAD;
                end
                else
                begin
                    leg_next = leg_reg + 3'd1;
                end
            end
            S_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                step_next    = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 3'd1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!status.out_stall)
                begin
                    cmd.out_load = 1'b1;
                    if (leg_reg == LAST_IDX)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        leg_next   = leg_reg + 3'd1;
                        state_next = S_DIV_LOAD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            leg_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            leg_reg   <= leg_next;
            step_reg  <= step_next;
        end
    end

endmodule

### sv/tpld_dp.sv
module tpld_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  tpld_pkg::in_word_t  in_data,
    input  tpld_pkg::cmd_t      cmd,
    output tpld_pkg::status_t   status,
    output logic                out_valid,
    input  logic                out_ready,
    output tpld_pkg::out_word_t out_data
);
    import tpld_pkg::*;

    logic [15:0] roll_gain_reg;
    logic [15:0] pitch_gain_reg;
    logic [14:0] deadband_reg;
    logic [15:0] min_norm_reg;

    in_word_t                 sample_reg;
    logic signed [TERM_W-1:0] rt_reg;
    logic signed [TERM_W-1:0] pt_reg;
    logic [MAG_W-1:0]         norm_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [REM_W-1:0]         dvs_reg;
    logic [7:0]               quo_reg;
    logic                     pos_reg;
    logic [7:0]               held_reg [LEG_COUNT];
    logic                     out_valid_reg;
    out_word_t                out_reg;

    logic signed [15:0]       angle_sel;
    logic [16:0]              angle_mag;
    logic signed [16:0]       mul_a;
    logic signed [16:0]       mul_b;
    logic signed [33:0]       prod;
    logic signed [ERR_W-1:0]  leg_err;
    logic [MAG_W-1:0]         leg_mag;
    logic [7:0]               duty_new;

    always_comb
    begin
        angle_sel = cmd.mul_pitch ? sample_reg.pitch_angle : sample_reg.roll_angle;
        angle_mag = angle_sel[15] ? 17'(-{angle_sel[15], angle_sel})
                                  : {1'b0, angle_sel};
        mul_a     = (angle_mag < {2'b00, deadband_reg}) ? '0 : {angle_sel[15], angle_sel};
        mul_b     = {1'b0, cmd.mul_pitch ? pitch_gain_reg : roll_gain_reg};
        prod      = mul_a * mul_b;
        leg_err   = leg_error(sample_reg.leg_set, cmd.leg, rt_reg, pt_reg);
        leg_mag   = err_mag(leg_err);
        duty_new  = (norm_reg == '0) ? 8'd0 : quo_reg;
    end

    assign status.out_stall = out_valid_reg && !out_ready;
    assign out_valid        = out_valid_reg;
    assign out_data         = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_gain_reg  <= ROLL_GAIN_RST;
            pitch_gain_reg <= PITCH_GAIN_RST;
            deadband_reg   <= ANGLE_DEADBAND_RST;
            min_norm_reg   <= MIN_NORMALIZER_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_ROLL_GAIN:      roll_gain_reg  <= cfg_data;
                REG_PITCH_GAIN:     pitch_gain_reg <= cfg_data;
                REG_ANGLE_DEADBAND: deadband_reg   <= cfg_data[14:0];
                REG_MIN_NORMALIZER: min_norm_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= in_data;
        end
        if (cmd.mul_roll)
        begin
            rt_reg <= prod[TERM_W-1:0];
        end
        if (cmd.mul_pitch)
        begin
            pt_reg   <= prod[TERM_W-1:0];
            norm_reg <= {9'd0, min_norm_reg, 8'd0};
        end
        if (cmd.norm_step && (leg_mag > norm_reg))
        begin
            norm_reg <= leg_mag;
        end
        if (cmd.div_load)
        begin
            rem_reg <= {leg_mag, 8'd0} - {8'd0, leg_mag};
            dvs_reg <= {1'b0, norm_reg, 7'd0};
            quo_reg <= '0;
            pos_reg <= !leg_err[ERR_W-1] && (leg_err != '0);
        end
        if (cmd.div_step)
        begin
            if (rem_reg >= dvs_reg)
            begin
                rem_reg <= rem_reg - dvs_reg;
                quo_reg <= {quo_reg[6:0], 1'b1};
            end
            else
            begin
                quo_reg <= {quo_reg[6:0], 1'b0};
            end
            dvs_reg <= dvs_reg >> 1;
        end
        if (cmd.out_load)
        begin
            out_reg.leg_number <= cmd.leg + FIRST_LEG;
            out_reg.last_leg   <= (cmd.leg == LAST_IDX);
            if (duty_new == 8'd0)
            begin
                out_reg.duty             <= held_reg[cmd.leg];
                out_reg.bridge_in_first  <= 1'b0;
                out_reg.bridge_in_second <= 1'b0;
            end
            else
            begin
                out_reg.duty             <= duty_new;
                out_reg.bridge_in_first  <= !pos_reg;
                out_reg.bridge_in_second <= pos_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < LEG_COUNT; i++)
            begin
                held_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
                if (duty_new != 8'd0)
                begin
                    held_reg[cmd.leg] <= duty_new;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
